// ===== rtl/rmslm_pkg.sv =====
// Shared types and constants for the RMS level meter.
`default_nettype none
package rmslm_pkg;

	localparam int unsigned SAMPLE_BITS    = 16;
	localparam int unsigned MAX_FRAMES_DEF = 4096;
	localparam int unsigned RMS_W          = 15;
	localparam int unsigned SQR_W          = 2 * SAMPLE_BITS - 1;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_sample;
		logic signed [SAMPLE_BITS-1:0] right_sample;
		logic                          last;
	} frame_t;

	typedef struct packed {
		logic [RMS_W-1:0] rms;
		logic             overflow;
	} level_t;

	// Per-frame control riding along with the lane squares.
	typedef struct packed {
		logic valid;
		logic add;
		logic last;
	} acc_ctrl_t;

	// Kick-off of the per-buffer divide and root.
	typedef struct packed {
		logic start;
		logic overflow;
	} eng_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/block_rms_level_meter_core.sv =====
// A last frame goes through the lane registers, the divide, the root and the output register.
// Throughput: one frame per cycle inside a buffer; after a last frame the input stalls
// while the shared divide (one quotient bit per cycle) and root (one bit pair per cycle) run.
// A result waiting in the output register does not stall new frames; one in the root unit does.
// Reset clears the sum of squares, frame count, overrun flag and all valid state.
`default_nettype none
module block_rms_level_meter_core #(
	parameter int unsigned MAX_FRAMES = rmslm_pkg::MAX_FRAMES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              frame_valid,
	output logic              frame_stall,
	input  rmslm_pkg::frame_t frame,
	output logic              level_valid,
	input  logic              level_stall,
	output rmslm_pkg::level_t level
);
	import rmslm_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_FRAMES + 1);
	localparam int unsigned SUM_W = 2 * SAMPLE_BITS + $clog2(MAX_FRAMES);

	logic             in_xfer;
	logic             room;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_inc;
	logic             ovf_q;
	logic [CNT_W-1:0] den_q;
	logic             ovf_fin_q;
	acc_ctrl_t        ctrl_s1;
	logic [SQR_W-1:0] sq_left_s1;
	logic [SQR_W-1:0] sq_right_s1;
	logic [SUM_W-1:0] sum_total;
	eng_cmd_t         cmd;
	logic             eng_busy;
	logic             eng_done;
	level_t           eng_result;
	logic             take;
	logic             level_valid_q;
	level_t           level_q;

	assign in_xfer     = frame_valid & ~frame_stall;
	assign frame_stall = (ctrl_s1.valid & ctrl_s1.last) | eng_busy;
	assign room        = count_q < CNT_W'(MAX_FRAMES);
	assign count_inc   = count_q + 1'b1;

	assign cmd.start    = ctrl_s1.valid & ctrl_s1.last;
	assign cmd.overflow = ovf_fin_q;

	assign take        = eng_done & (~level_valid_q | ~level_stall);
	assign level_valid = level_valid_q;
	assign level       = level_q;

	rmslm_lane u_lane_left (
		.clk       (clk),
		.en        (in_xfer),
		.sample    (frame.left_sample),
		.square_s1 (sq_left_s1)
	);

	rmslm_lane u_lane_right (
		.clk       (clk),
		.en        (in_xfer),
		.sample    (frame.right_sample),
		.square_s1 (sq_right_s1)
	);

	rmslm_accum #(
		.SUM_W (SUM_W)
	) u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl_s1     (ctrl_s1),
		.sq_left_s1  (sq_left_s1),
		.sq_right_s1 (sq_right_s1),
		.sum_total   (sum_total)
	);

	rmslm_root_unit #(
		.SUM_W (SUM_W),
		.CNT_W (CNT_W)
	) u_root (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.dividend (sum_total),
		.divisor  (den_q),
		.take     (take),
		.busy     (eng_busy),
		.done     (eng_done),
		.result   (eng_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			ctrl_s1.valid <= in_xfer;
			ctrl_s1.add   <= room;
			ctrl_s1.last  <= frame.last;
			if (in_xfer) begin
				if (frame.last) begin
					count_q <= '0;
					ovf_q   <= 1'b0;
				end else if (room) begin
					count_q <= count_inc;
				end else begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	// Hold the final count and overrun flag for the root unit.
	always_ff @(posedge clk) begin
		if (in_xfer && frame.last) begin
			den_q     <= room ? count_inc : count_q;
			ovf_fin_q <= ovf_q | ~room;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_valid_q <= 1'b0;
		end else if (take) begin
			level_valid_q <= 1'b1;
		end else if (!level_stall) begin
			level_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			level_q <= eng_result;
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_FRAMES))
		else $error("frame count above limit");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !eng_busy)
		else $error("buffer handed to busy root unit");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.start && ovf_fin_q) |-> (den_q == CNT_W'(MAX_FRAMES)))
		else $error("overflow flagged without a full count");

	a_last_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && frame.last) |=> frame_stall)
		else $error("frame taken right after a last frame");

endmodule
`default_nettype wire

// ===== rtl/rmslm_lane.sv =====
// One sample lane: magnitude and square of a signed sample, registered.
`default_nettype none
module rmslm_lane (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic signed [rmslm_pkg::SAMPLE_BITS-1:0] sample,
	output logic [rmslm_pkg::SQR_W-1:0]            square_s1
);
	import rmslm_pkg::*;

	logic [SAMPLE_BITS-1:0]   raw;
	logic [SAMPLE_BITS-1:0]   mag;
	logic [2*SAMPLE_BITS-1:0] prod;

	assign raw  = sample;
	// Most negative code maps to 2^(SAMPLE_BITS-1), which still fits unsigned.
	assign mag  = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
	assign prod = mag * mag;

	always_ff @(posedge clk) begin
		if (en) begin
			square_s1 <= prod[SQR_W-1:0];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/rmslm_accum.sv =====
// Merge stage: adds both lane squares into the buffer sum of squares while the count has room.
`default_nettype none
module rmslm_accum #(
	parameter int unsigned SUM_W = 44
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rmslm_pkg::acc_ctrl_t          ctrl_s1,
	input  logic [rmslm_pkg::SQR_W-1:0]   sq_left_s1,
	input  logic [rmslm_pkg::SQR_W-1:0]   sq_right_s1,
	output logic [SUM_W-1:0]              sum_total
);
	import rmslm_pkg::*;

	logic [SUM_W-1:0] sum_q;
	logic [SQR_W:0]   frame_sum;

	assign frame_sum = {1'b0, sq_left_s1} + {1'b0, sq_right_s1};
	assign sum_total = sum_q + (ctrl_s1.add ? SUM_W'(frame_sum) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctrl_s1.valid) begin
			// drop the sum once the buffer is handed to the root unit
			sum_q <= ctrl_s1.last ? '0 : sum_total;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/rmslm_root_unit.sv =====
// Per-buffer sequencer: restoring divide by the frame count, then bit-pair square root.
`default_nettype none
module rmslm_root_unit #(
	parameter int unsigned SUM_W = 44,
	parameter int unsigned CNT_W = 13
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rmslm_pkg::eng_cmd_t   cmd,
	input  logic [SUM_W-1:0]      dividend,
	input  logic [CNT_W-1:0]      divisor,
	input  logic                  take,
	output logic                  busy,
	output logic                  done,
	output rmslm_pkg::level_t     result
);
	import rmslm_pkg::*;

	localparam int unsigned MEAN_W = SUM_W - 3;
	localparam int unsigned SQ_N   = (MEAN_W + 1) / 2;
	localparam int unsigned SQ_W   = 2 * SQ_N;
	localparam int unsigned STEP_W = $clog2(SUM_W);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_SQRT = 4'b0100,
		ST_DONE = 4'b1000
	} eng_state_t;

	eng_state_t        state_q;
	logic [STEP_W-1:0] step_q;
	logic [SUM_W-1:0]  quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  den_q;
	logic              ovf_q;
	logic [SQ_W-1:0]   x_q;
	logic [SQ_N:0]     srem_q;
	logic [SQ_N-1:0]   root_q;

	logic [CNT_W:0]    div_shift;
	logic [CNT_W:0]    div_diff;
	logic              div_fits;
	logic [SUM_W-1:0]  quo_nxt;
	logic [SQ_N+2:0]   sq_shift;
	logic [SQ_N+2:0]   sq_trial;
	logic [SQ_N+2:0]   sq_diff;
	logic              sq_fits;

	assign div_shift = {rem_q, quo_q[SUM_W-1]};
	assign div_diff  = div_shift - {1'b0, den_q};
	assign div_fits  = div_shift >= {1'b0, den_q};
	assign quo_nxt   = {quo_q[SUM_W-2:0], div_fits};

	assign sq_shift  = {srem_q, x_q[SQ_W-1 -: 2]};
	assign sq_trial  = {1'b0, root_q, 2'b01};
	assign sq_diff   = sq_shift - sq_trial;
	assign sq_fits   = sq_shift >= sq_trial;

	assign busy            = (state_q != ST_IDLE);
	assign done            = (state_q == ST_DONE);
	assign result.rms      = root_q[RMS_W-1:0];
	assign result.overflow = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						state_q <= ST_DIV;
						step_q  <= STEP_W'(SUM_W - 1);
					end
				end
				ST_DIV: begin
					if (step_q == '0) begin
						state_q <= ST_SQRT;
						step_q  <= STEP_W'(SQ_N - 1);
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				ST_SQRT: begin
					if (step_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cmd.start) begin
					quo_q <= dividend;
					rem_q <= '0;
					den_q <= divisor;
					ovf_q <= cmd.overflow;
				end
			end
			ST_DIV: begin
				quo_q <= quo_nxt;
				rem_q <= div_fits ? div_diff[CNT_W-1:0] : div_shift[CNT_W-1:0];
				if (step_q == '0) begin
					// quotient over eight is the mean square of the half-scaled samples
					x_q    <= SQ_W'(quo_nxt[SUM_W-1:3]);
					srem_q <= '0;
					root_q <= '0;
				end
			end
			ST_SQRT: begin
				x_q    <= x_q << 2;
				srem_q <= sq_fits ? sq_diff[SQ_N:0] : sq_shift[SQ_N:0];
				root_q <= {root_q[SQ_N-2:0], sq_fits};
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire
